// File: rtl/ohp_pkg.sv
// Package for the Opus identification header parser.
// Holds header layout constants, status codes, the result record and the magic table.
// No dependencies; all other files of the block use it by scoped names.
package ohp_pkg;

    localparam int HEAD_MIN_LEN      = 19;
    localparam int MAP_START         = 21;
    localparam int COUNT_LIMIT       = 255;
    localparam int POS_MAX           = 511;
    localparam int MAX_CHANNELS      = 255;
    localparam int RESULT_FIFO_DEPTH = 4;

    localparam logic [7:0] MAJOR_MASK = 8'hF0;

    // Byte positions inside the identification header.
    localparam logic [8:0] POS_VERSION  = 9'd8;
    localparam logic [8:0] POS_CHANNELS = 9'd9;
    localparam logic [8:0] POS_SKIP_LO  = 9'd10;
    localparam logic [8:0] POS_SKIP_HI  = 9'd11;
    localparam logic [8:0] POS_RATE_B0  = 9'd12;
    localparam logic [8:0] POS_RATE_B1  = 9'd13;
    localparam logic [8:0] POS_RATE_B2  = 9'd14;
    localparam logic [8:0] POS_RATE_B3  = 9'd15;
    localparam logic [8:0] POS_GAIN_LO  = 9'd16;
    localparam logic [8:0] POS_GAIN_HI  = 9'd17;
    localparam logic [8:0] POS_FAMILY   = 9'd18;
    localparam logic [8:0] POS_STREAMS  = 9'd19;
    localparam logic [8:0] POS_COUPLED  = 9'd20;

    typedef enum logic [3:0] {
        STATUS_OK          = 4'd0,
        STATUS_SHORT       = 4'd1,
        STATUS_MAGIC       = 4'd2,
        STATUS_VERSION     = 4'd3,
        STATUS_NO_CHANNELS = 4'd4,
        STATUS_FAM0_CHANS  = 4'd5,
        STATUS_NO_STREAMS  = 4'd6,
        STATUS_COUPLED     = 4'd7,
        STATUS_COUNT_SUM   = 4'd8
    } status_t;

    typedef enum logic {
        KIND_ENTRY   = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t              result_kind;
        status_t            status;
        logic [7:0]         version;
        logic [7:0]         num_channels;
        logic [15:0]        skip_samples;
        logic [31:0]        sample_rate_hz;
        logic signed [15:0] output_gain;
        logic [7:0]         map_family;
        logic [7:0]         num_streams;
        logic [7:0]         num_coupled;
        logic [7:0]         entry_index;
        logic [7:0]         entry_value;
    } result_t;

    // Expected characters of the "OpusHead" signature.
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] ch;
        begin
            case (idx)
                3'd0:    ch = 8'h4F;
                3'd1:    ch = 8'h70;
                3'd2:    ch = 8'h75;
                3'd3:    ch = 8'h73;
                3'd4:    ch = 8'h48;
                3'd5:    ch = 8'h65;
                3'd6:    ch = 8'h61;
                3'd7:    ch = 8'h64;
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

// File: rtl/ohp_ifs.sv
// Valid/ready channel interfaces of the Opus header parser.
// ohp_in_if carries header bytes, ohp_out_if carries result records.
// Depends on ohp_pkg for the kind type.
interface ohp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ohp_out_if;
    logic               valid;
    logic               ready;
    ohp_pkg::kind_t     result_kind;
    logic [3:0]         status;
    logic [7:0]         version;
    logic [7:0]         num_channels;
    logic [15:0]        skip_samples;
    logic [31:0]        sample_rate_hz;
    logic signed [15:0] output_gain;
    logic [7:0]         map_family;
    logic [7:0]         num_streams;
    logic [7:0]         num_coupled;
    logic [7:0]         entry_index;
    logic [7:0]         entry_value;

    modport source (
        output valid, output result_kind, output status, output version,
        output num_channels, output skip_samples, output sample_rate_hz,
        output output_gain, output map_family, output num_streams,
        output num_coupled, output entry_index, output entry_value,
        input ready
    );
    modport sink (
        input valid, input result_kind, input status, input version,
        input num_channels, input skip_samples, input sample_rate_hz,
        input output_gain, input map_family, input num_streams,
        input num_coupled, input entry_index, input entry_value,
        output ready
    );
endinterface

// File: rtl/ohp_result_fifo.sv
// Result queue of the Opus header parser: takes up to two records per cycle,
// gives one per cycle from registers while pop is held. Depends on ohp_pkg for result_t.
module ohp_result_fifo #(
    parameter int DEPTH = ohp_pkg::RESULT_FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_a,
    input  logic             push_b,
    input  ohp_pkg::result_t data_a,
    input  ohp_pkg::result_t data_b,
    input  logic             pop,
    output logic             out_valid,
    output ohp_pkg::result_t out_data,
    output logic             room_two
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);

    ohp_pkg::result_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        begin
            return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
        end
    endfunction

    assign out_valid    = (count_reg != '0);
    assign out_data     = mem_reg[rd_ptr_reg];
    assign room_two     = (count_reg <= ROOM_LIMIT);
    assign do_pop       = pop && out_valid;
    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push_a && push_b)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_plus1);
        end
        else if (push_a)
        begin
            wr_ptr_next = wr_ptr_plus1;
        end
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            mem_reg[wr_ptr_reg] <= data_a;
        end
        if (push_a && push_b)
        begin
            mem_reg[wr_ptr_plus1] <= data_b;
        end
    end

endmodule

// File: rtl/opus_id_header_parser.sv
// Opus identification header parser, one header byte per request.
// The header channel delivers data_byte with last_byte set on the packet's
// final byte. Each byte is checked or captured at its position as it is taken.
// For a non-zero mapping family every mapping byte below the channel count
// yields an entry result; the last byte yields a summary result with status,
// after the entry when that byte is also a mapping byte.
// A result is written into the registered result queue when the byte that caused
// it is taken, and is offered from there behind any records still waiting. Bytes are
// taken one per cycle while the queue has room; a byte that yields two results writes both.
// The input is ready whenever the result queue (FIFO_DEPTH records) has room
// for two records, so header ready does not depend on result ready in the
// same cycle. When the receiver stalls, the queue fills and header ready drops
// until records drain; nothing is lost or repeated.
// Reset clears the byte position, captured fields and magic error flag, and
// empties the result queue. The parser also clears itself after every last byte.
module opus_id_header_parser #(
    parameter int FIFO_DEPTH = ohp_pkg::RESULT_FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    ohp_in_if.sink      header,
    ohp_out_if.source   result
);

    logic [8:0]         pos_reg, pos_next;
    logic [7:0]         version_reg, version_next;
    logic [7:0]         chans_reg, chans_next;
    logic [15:0]        skip_reg, skip_next;
    logic [31:0]        rate_reg, rate_next;
    logic [15:0]        gain_reg, gain_next;
    logic [7:0]         family_reg, family_next;
    logic [7:0]         streams_reg, streams_next;
    logic [7:0]         coupled_reg, coupled_next;
    logic               magic_err_reg, magic_err_next;

    logic               take;
    logic [7:0]         b;
    logic [8:0]         map_idx;
    logic               entry_hit;
    logic [9:0]         need_len;
    logic [8:0]         count_sum;
    ohp_pkg::status_t   st;
    logic [7:0]         sum_streams;
    logic [7:0]         sum_coupled;
    ohp_pkg::result_t   entry_rec;
    ohp_pkg::result_t   summary_rec;
    ohp_pkg::result_t   rec_a;
    ohp_pkg::result_t   out_rec;
    logic               push_a;
    logic               push_b;
    logic               room_two;
    logic               out_valid;

    assign b    = header.data_byte;
    assign take = header.valid && header.ready;

    // Field capture at fixed byte positions.
    always_comb
    begin
        version_next   = version_reg;
        chans_next     = chans_reg;
        skip_next      = skip_reg;
        rate_next      = rate_reg;
        gain_next      = gain_reg;
        family_next    = family_reg;
        streams_next   = streams_reg;
        coupled_next   = coupled_reg;
        magic_err_next = magic_err_reg;
        if (pos_reg < 9'd8)
        begin
            if (b != ohp_pkg::magic_byte(pos_reg[2:0]))
            begin
                magic_err_next = 1'b1;
            end
        end
        else
        begin
            case (pos_reg)
                ohp_pkg::POS_VERSION:  version_next     = b;
                ohp_pkg::POS_CHANNELS: chans_next       = b;
                ohp_pkg::POS_SKIP_LO:  skip_next[7:0]   = b;
                ohp_pkg::POS_SKIP_HI:  skip_next[15:8]  = b;
                ohp_pkg::POS_RATE_B0:  rate_next[7:0]   = b;
                ohp_pkg::POS_RATE_B1:  rate_next[15:8]  = b;
                ohp_pkg::POS_RATE_B2:  rate_next[23:16] = b;
                ohp_pkg::POS_RATE_B3:  rate_next[31:24] = b;
                ohp_pkg::POS_GAIN_LO:  gain_next[7:0]   = b;
                ohp_pkg::POS_GAIN_HI:  gain_next[15:8]  = b;
                ohp_pkg::POS_FAMILY:   family_next      = b;
                ohp_pkg::POS_STREAMS:
                begin
                    if (family_reg != 8'd0)
                    begin
                        streams_next = b;
                    end
                end
                ohp_pkg::POS_COUPLED:
                begin
                    if (family_reg != 8'd0)
                    begin
                        coupled_next = b;
                    end
                end
                default: ;
            endcase
        end
        pos_next = (pos_reg == 9'(ohp_pkg::POS_MAX)) ? pos_reg : pos_reg + 9'd1;
    end

    // Mapping entries for a non-zero family.
    assign map_idx   = pos_reg - 9'(ohp_pkg::MAP_START);
    assign entry_hit = (family_reg != 8'd0)
                    && (pos_reg >= 9'(ohp_pkg::MAP_START))
                    && (pos_reg < 9'(ohp_pkg::POS_MAX))
                    && (map_idx < {1'b0, chans_reg})
                    && (map_idx < 9'(ohp_pkg::MAX_CHANNELS));

    // Status: the first failing check in order decides.
    assign need_len  = 10'(ohp_pkg::MAP_START) + {2'b00, chans_next};
    assign count_sum = {1'b0, streams_next} + {1'b0, coupled_next};

    always_comb
    begin
        if (pos_next < 9'(ohp_pkg::HEAD_MIN_LEN))
        begin
            st = ohp_pkg::STATUS_SHORT;
        end
        else if (magic_err_next)
        begin
            st = ohp_pkg::STATUS_MAGIC;
        end
        else if ((version_next & ohp_pkg::MAJOR_MASK) != 8'd0)
        begin
            st = ohp_pkg::STATUS_VERSION;
        end
        else if (chans_next == 8'd0)
        begin
            st = ohp_pkg::STATUS_NO_CHANNELS;
        end
        else if (family_next == 8'd0)
        begin
            st = (chans_next > 8'd2) ? ohp_pkg::STATUS_FAM0_CHANS : ohp_pkg::STATUS_OK;
        end
        else if ({1'b0, pos_next} < need_len)
        begin
            st = ohp_pkg::STATUS_SHORT;
        end
        else if (streams_next == 8'd0)
        begin
            st = ohp_pkg::STATUS_NO_STREAMS;
        end
        else if (coupled_next > streams_next)
        begin
            st = ohp_pkg::STATUS_COUPLED;
        end
        else if (count_sum > 9'(ohp_pkg::COUNT_LIMIT))
        begin
            st = ohp_pkg::STATUS_COUNT_SUM;
        end
        else
        begin
            st = ohp_pkg::STATUS_OK;
        end
    end

    // Family 0 reports the implied counts, but only for a good header.
    always_comb
    begin
        sum_streams = streams_next;
        sum_coupled = coupled_next;
        if (family_next == 8'd0)
        begin
            if (st == ohp_pkg::STATUS_OK)
            begin
                sum_streams = 8'd1;
                sum_coupled = (chans_next >= 8'd2) ? 8'd1 : 8'd0;
            end
            else
            begin
                sum_streams = 8'd0;
                sum_coupled = 8'd0;
            end
        end
    end

    always_comb
    begin
        entry_rec             = '0;
        entry_rec.result_kind = ohp_pkg::KIND_ENTRY;
        entry_rec.status      = ohp_pkg::STATUS_OK;
        entry_rec.entry_index = map_idx[7:0];
        entry_rec.entry_value = b;

        summary_rec                = '0;
        summary_rec.result_kind    = ohp_pkg::KIND_SUMMARY;
        summary_rec.status         = st;
        summary_rec.version        = version_next;
        summary_rec.num_channels   = chans_next;
        summary_rec.skip_samples   = skip_next;
        summary_rec.sample_rate_hz = rate_next;
        summary_rec.output_gain    = gain_next;
        summary_rec.map_family     = family_next;
        summary_rec.num_streams    = sum_streams;
        summary_rec.num_coupled    = sum_coupled;
    end

    // When both results occur, the entry goes first.
    assign push_a = take && (entry_hit || header.last_byte);
    assign push_b = take && entry_hit && header.last_byte;
    assign rec_a  = entry_hit ? entry_rec : summary_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            version_reg   <= '0;
            chans_reg     <= '0;
            skip_reg      <= '0;
            rate_reg      <= '0;
            gain_reg      <= '0;
            family_reg    <= '0;
            streams_reg   <= '0;
            coupled_reg   <= '0;
            magic_err_reg <= 1'b0;
        end
        else if (take)
        begin
            if (header.last_byte)
            begin
                pos_reg       <= '0;
                version_reg   <= '0;
                chans_reg     <= '0;
                skip_reg      <= '0;
                rate_reg      <= '0;
                gain_reg      <= '0;
                family_reg    <= '0;
                streams_reg   <= '0;
                coupled_reg   <= '0;
                magic_err_reg <= 1'b0;
            end
            else
            begin
                pos_reg       <= pos_next;
                version_reg   <= version_next;
                chans_reg     <= chans_next;
                skip_reg      <= skip_next;
                rate_reg      <= rate_next;
                gain_reg      <= gain_next;
                family_reg    <= family_next;
                streams_reg   <= streams_next;
                coupled_reg   <= coupled_next;
                magic_err_reg <= magic_err_next;
            end
        end
    end

    ohp_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (push_a),
        .push_b    (push_b),
        .data_a    (rec_a),
        .data_b    (summary_rec),
        .pop       (result.ready),
        .out_valid (out_valid),
        .out_data  (out_rec),
        .room_two  (room_two)
    );

    assign header.ready          = room_two;
    assign result.valid          = out_valid;
    assign result.result_kind    = out_rec.result_kind;
    assign result.status         = out_rec.status;
    assign result.version        = out_rec.version;
    assign result.num_channels   = out_rec.num_channels;
    assign result.skip_samples   = out_rec.skip_samples;
    assign result.sample_rate_hz = out_rec.sample_rate_hz;
    assign result.output_gain    = out_rec.output_gain;
    assign result.map_family     = out_rec.map_family;
    assign result.num_streams    = out_rec.num_streams;
    assign result.num_coupled    = out_rec.num_coupled;
    assign result.entry_index    = out_rec.entry_index;
    assign result.entry_value    = out_rec.entry_value;

endmodule
